// ----- rtl/czd_pkg.sv -----
package czd_pkg;

    localparam int unsigned LUMA_W    = 8;
    localparam int unsigned POS_W     = 10;
    localparam int unsigned CNT_W     = 21;
    localparam int unsigned SUM_W     = 31;
    localparam int unsigned THR_W     = 8;
    localparam int unsigned FRAC_W    = 16;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DAT_W = 16;
    localparam int unsigned PROD_W    = FRAC_W + CNT_W;
    localparam int unsigned DSH_W     = CNT_W + POS_W - 1;
    localparam int unsigned STEP_W    = 4;
    localparam int unsigned POS_CMP_W = 13;

    localparam int unsigned MAX_COLS = 1024;
    localparam int unsigned MAX_ROWS = 1024;

    localparam logic [CNT_W-1:0]  CNT_MAX    = {CNT_W{1'b1}};
    localparam logic [THR_W-1:0]  THR_RESET  = 8'd25;
    localparam logic [FRAC_W-1:0] FRAC_RESET = 16'd1311;
    localparam logic [STEP_W-1:0] STEP_LAST  = STEP_W'(POS_W - 1);

    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRACTION  = 2'd1;

    typedef struct packed {
        logic [LUMA_W-1:0] cur_luma;
        logic [LUMA_W-1:0] ref_luma;
        logic              in_zone;
        logic [POS_W-1:0]  pix_x;
        logic [POS_W-1:0]  pix_y;
        logic              frame_end;
    } pix_word_t;

    typedef struct packed {
        logic              person_present;
        logic [POS_W-1:0]  centroid_x;
        logic [POS_W-1:0]  centroid_y;
        logic [CNT_W-1:0]  changed_count;
        logic [CNT_W-1:0]  zone_pixels;
        logic              centroid_fresh;
    } res_word_t;

    typedef struct packed {
        logic start;
        logic release_ok;
    } fin_ctl_t;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic             present;
        logic             fresh;
        logic [POS_W-1:0] cx;
        logic [POS_W-1:0] cy;
    } fin_stat_t;

    typedef enum logic [5:0] {
        FS_IDLE  = 6'b000001,
        FS_LOAD  = 6'b000010,
        FS_DIV_X = 6'b000100,
        FS_DIV_Y = 6'b001000,
        FS_CMP   = 6'b010000,
        FS_DONE  = 6'b100000
    } fin_state_t;

endpackage

// ----- rtl/zone_change_presence_detector.sv -----
// channel | direction | handshake            | word
// pix     | in        | pix_valid/pix_stall  | pix_data (czd_pkg::pix_word_t)
// res     | out       | res_valid/res_stall  | res_data (czd_pkg::res_word_t)
// cfg     | in        | cfg_we               | cfg_index, cfg_data
//
// Ordinary pixels: one word per cycle while pix_stall is low.
// Frame-end pixel: pix_stall while the finish steps run (load, X and Y division
// on the shared compare/subtract divider, compare, hand-off), with no division
// when no pixel changed, longer while the result register is held by res_stall.
// The result register lets a new frame start while the last result waits.
// rst_n is asynchronous; counters, sums and held centroid clear to zero.
module zone_change_presence_detector (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            pix_valid,
    output logic                            pix_stall,
    input  czd_pkg::pix_word_t              pix_data,
    output logic                            res_valid,
    input  logic                            res_stall,
    output czd_pkg::res_word_t              res_data,
    input  logic                            cfg_we,
    input  logic [czd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [czd_pkg::CFG_DAT_W-1:0]   cfg_data
);

    logic [czd_pkg::THR_W-1:0]  thr_reg, thr_next;
    logic [czd_pkg::FRAC_W-1:0] frac_reg, frac_next;
    logic                       res_valid_reg, res_valid_next;
    czd_pkg::res_word_t         res_data_reg, res_data_next;

    logic                       pix_take;
    logic                       load_res;
    logic [czd_pkg::CNT_W-1:0]  hit_cnt;
    logic [czd_pkg::CNT_W-1:0]  zone_cnt;
    logic [czd_pkg::SUM_W-1:0]  sum_col;
    logic [czd_pkg::SUM_W-1:0]  sum_row;
    czd_pkg::fin_ctl_t          fin_ctl;
    czd_pkg::fin_stat_t         fin_stat;

    assign pix_stall = fin_stat.busy;
    assign pix_take  = pix_valid && !fin_stat.busy;
    assign load_res  = fin_stat.done && (!res_valid_reg || !res_stall);

    always_comb
    begin
        fin_ctl.start      = pix_take && pix_data.frame_end;
        fin_ctl.release_ok = load_res;
    end

    czd_accum u_accum (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (pix_take),
        .clear     (load_res),
        .pix       (pix_data),
        .threshold (thr_reg),
        .hit_cnt   (hit_cnt),
        .zone_cnt  (zone_cnt),
        .sum_col   (sum_col),
        .sum_row   (sum_row)
    );

    czd_finish u_finish (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (fin_ctl),
        .hit_cnt  (hit_cnt),
        .zone_cnt (zone_cnt),
        .sum_col  (sum_col),
        .sum_row  (sum_row),
        .fraction (frac_reg),
        .stat     (fin_stat)
    );

    always_comb
    begin
        thr_next  = thr_reg;
        frac_next = frac_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                czd_pkg::CFG_THRESHOLD: thr_next  = cfg_data[czd_pkg::THR_W-1:0];
                czd_pkg::CFG_FRACTION:  frac_next = cfg_data[czd_pkg::FRAC_W-1:0];
                default:                ;
            endcase
        end
    end

    always_comb
    begin
        res_valid_next = res_valid_reg && res_stall;
        res_data_next  = res_data_reg;
        if (load_res)
        begin
            res_valid_next               = 1'b1;
            res_data_next.person_present = fin_stat.present;
            res_data_next.centroid_x     = fin_stat.cx;
            res_data_next.centroid_y     = fin_stat.cy;
            res_data_next.changed_count  = hit_cnt;
            res_data_next.zone_pixels    = zone_cnt;
            res_data_next.centroid_fresh = fin_stat.fresh;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg       <= czd_pkg::THR_RESET;
            frac_reg      <= czd_pkg::FRAC_RESET;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            thr_reg       <= thr_next;
            frac_reg      <= frac_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_data_reg <= res_data_next;
    end

    assign res_valid = res_valid_reg;
    assign res_data  = res_data_reg;

endmodule

// ----- rtl/czd_accum.sv -----
module czd_accum (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        clear,
    input  czd_pkg::pix_word_t          pix,
    input  logic [czd_pkg::THR_W-1:0]   threshold,
    output logic [czd_pkg::CNT_W-1:0]   hit_cnt,
    output logic [czd_pkg::CNT_W-1:0]   zone_cnt,
    output logic [czd_pkg::SUM_W-1:0]   sum_col,
    output logic [czd_pkg::SUM_W-1:0]   sum_row
);

    logic [czd_pkg::CNT_W-1:0]  hit_reg, hit_next;
    logic [czd_pkg::CNT_W-1:0]  zone_reg, zone_next;
    logic [czd_pkg::SUM_W-1:0]  scol_reg, scol_next;
    logic [czd_pkg::SUM_W-1:0]  srow_reg, srow_next;
    logic [czd_pkg::LUMA_W-1:0] diff;
    logic                       in_frame;
    logic                       zone_ok;
    logic                       changed;

    always_comb
    begin
        in_frame = ({{(czd_pkg::POS_CMP_W - czd_pkg::POS_W){1'b0}}, pix.pix_x}
                    < czd_pkg::POS_CMP_W'(czd_pkg::MAX_COLS))
                && ({{(czd_pkg::POS_CMP_W - czd_pkg::POS_W){1'b0}}, pix.pix_y}
                    < czd_pkg::POS_CMP_W'(czd_pkg::MAX_ROWS));
        zone_ok  = pix.in_zone && in_frame;
        diff     = (pix.cur_luma > pix.ref_luma) ? pix.cur_luma - pix.ref_luma
                                                 : pix.ref_luma - pix.cur_luma;
        changed  = zone_ok && (diff > threshold) && (hit_reg != czd_pkg::CNT_MAX);

        hit_next  = hit_reg;
        zone_next = zone_reg;
        scol_next = scol_reg;
        srow_next = srow_reg;
        if (clear)
        begin
            hit_next  = '0;
            zone_next = '0;
            scol_next = '0;
            srow_next = '0;
        end
        else if (en)
        begin
            if (zone_ok && zone_reg != czd_pkg::CNT_MAX)
            begin
                zone_next = zone_reg + 1'b1;
            end
            if (changed)
            begin
                hit_next  = hit_reg + 1'b1;
                scol_next = scol_reg + czd_pkg::SUM_W'(pix.pix_x);
                srow_next = srow_reg + czd_pkg::SUM_W'(pix.pix_y);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg  <= '0;
            zone_reg <= '0;
            scol_reg <= '0;
            srow_reg <= '0;
        end
        else
        begin
            hit_reg  <= hit_next;
            zone_reg <= zone_next;
            scol_reg <= scol_next;
            srow_reg <= srow_next;
        end
    end

    assign hit_cnt  = hit_reg;
    assign zone_cnt = zone_reg;
    assign sum_col  = scol_reg;
    assign sum_row  = srow_reg;

endmodule

// ----- rtl/czd_finish.sv -----
module czd_finish (
    input  logic                        clk,
    input  logic                        rst_n,
    input  czd_pkg::fin_ctl_t           ctl,
    input  logic [czd_pkg::CNT_W-1:0]   hit_cnt,
    input  logic [czd_pkg::CNT_W-1:0]   zone_cnt,
    input  logic [czd_pkg::SUM_W-1:0]   sum_col,
    input  logic [czd_pkg::SUM_W-1:0]   sum_row,
    input  logic [czd_pkg::FRAC_W-1:0]  fraction,
    output czd_pkg::fin_stat_t          stat
);

    czd_pkg::fin_state_t         state_reg, state_next;
    logic [czd_pkg::SUM_W-1:0]   rem_reg, rem_next;
    logic [czd_pkg::DSH_W-1:0]   dsh_reg, dsh_next;
    logic [czd_pkg::POS_W-1:0]   quo_reg, quo_next;
    logic [czd_pkg::STEP_W-1:0]  step_reg, step_next;
    logic [czd_pkg::PROD_W-1:0]  prod_reg, prod_next;
    logic [czd_pkg::POS_W-1:0]   cx_reg, cx_next;
    logic [czd_pkg::POS_W-1:0]   cy_reg, cy_next;
    logic                        present_reg, present_next;
    logic                        fresh_reg, fresh_next;

    // shared compare/subtract: one quotient bit per cycle
    logic                        fits;
    logic [czd_pkg::SUM_W-1:0]   rem_sub;
    logic [czd_pkg::POS_W-1:0]   quo_step;
    logic [czd_pkg::DSH_W-1:0]   dsh_init;

    always_comb
    begin
        fits     = rem_reg >= {1'b0, dsh_reg};
        rem_sub  = fits ? rem_reg - {1'b0, dsh_reg} : rem_reg;
        quo_step = {quo_reg[czd_pkg::POS_W-2:0], fits};
        dsh_init = {hit_cnt, {(czd_pkg::POS_W - 1){1'b0}}};

        state_next   = state_reg;
        rem_next     = rem_reg;
        dsh_next     = dsh_reg;
        quo_next     = quo_reg;
        step_next    = step_reg;
        prod_next    = prod_reg;
        cx_next      = cx_reg;
        cy_next      = cy_reg;
        present_next = present_reg;
        fresh_next   = fresh_reg;

        unique case (state_reg)
            czd_pkg::FS_IDLE:
            begin
                if (ctl.start)
                begin
                    state_next = czd_pkg::FS_LOAD;
                end
            end
            czd_pkg::FS_LOAD:
            begin
                rem_next   = sum_col;
                dsh_next   = dsh_init;
                quo_next   = '0;
                step_next  = czd_pkg::STEP_LAST;
                prod_next  = czd_pkg::PROD_W'(fraction) * czd_pkg::PROD_W'(zone_cnt);
                fresh_next = hit_cnt != '0;
                state_next = (hit_cnt != '0) ? czd_pkg::FS_DIV_X : czd_pkg::FS_CMP;
            end
            czd_pkg::FS_DIV_X:
            begin
                rem_next  = rem_sub;
                dsh_next  = dsh_reg >> 1;
                quo_next  = quo_step;
                step_next = step_reg - 1'b1;
                if (step_reg == '0)
                begin
                    cx_next    = quo_step;
                    rem_next   = sum_row;
                    dsh_next   = dsh_init;
                    quo_next   = '0;
                    step_next  = czd_pkg::STEP_LAST;
                    state_next = czd_pkg::FS_DIV_Y;
                end
            end
            czd_pkg::FS_DIV_Y:
            begin
                rem_next  = rem_sub;
                dsh_next  = dsh_reg >> 1;
                quo_next  = quo_step;
                step_next = step_reg - 1'b1;
                if (step_reg == '0)
                begin
                    cy_next    = quo_step;
                    state_next = czd_pkg::FS_CMP;
                end
            end
            czd_pkg::FS_CMP:
            begin
                present_next = (zone_cnt != '0)
                            && ({hit_cnt, {czd_pkg::FRAC_W{1'b0}}} > prod_reg);
                state_next   = czd_pkg::FS_DONE;
            end
            czd_pkg::FS_DONE:
            begin
                if (ctl.release_ok)
                begin
                    state_next = czd_pkg::FS_IDLE;
                end
            end
            default:
            begin
                state_next = czd_pkg::FS_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= czd_pkg::FS_IDLE;
            cx_reg      <= '0;
            cy_reg      <= '0;
            present_reg <= 1'b0;
            fresh_reg   <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cx_reg      <= cx_next;
            cy_reg      <= cy_next;
            present_reg <= present_next;
            fresh_reg   <= fresh_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        dsh_reg  <= dsh_next;
        quo_reg  <= quo_next;
        step_reg <= step_next;
        prod_reg <= prod_next;
    end

    always_comb
    begin
        stat.busy    = state_reg != czd_pkg::FS_IDLE;
        stat.done    = state_reg == czd_pkg::FS_DONE;
        stat.present = present_reg;
        stat.fresh   = fresh_reg;
        stat.cx      = cx_reg;
        stat.cy      = cy_reg;
    end

endmodule

// ----- rtl/czd_checker.sv -----
module czd_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               pix_valid,
    input  logic               pix_stall,
    input  czd_pkg::pix_word_t pix_data,
    input  logic               res_valid,
    input  logic               res_stall,
    input  czd_pkg::res_word_t res_data
);

    // frame end starts the finish sequence, so the next pixel waits
    a_frame_end_busy: assert property (@(posedge clk) disable iff (!rst_n)
        pix_valid && !pix_stall && pix_data.frame_end |=> pix_stall)
        else $error("no stall after frame end word");

    a_hit_le_zone: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> res_data.changed_count <= res_data.zone_pixels)
        else $error("changed count above zone count");

    a_empty_zone: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_data.zone_pixels == '0 |-> !res_data.person_present)
        else $error("presence with empty zone");

    a_fresh: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> res_data.centroid_fresh == (res_data.changed_count != '0))
        else $error("centroid_fresh disagrees with changed count");

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(res_data))
        else $error("stalled result word changed");

endmodule

bind zone_change_presence_detector czd_checker u_czd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .pix_valid (pix_valid),
    .pix_stall (pix_stall),
    .pix_data  (pix_data),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_data  (res_data)
);
